>>> rtl/core/srq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srq_pkg: shared types for the selective-repeat sender
// Item structs, event/result codes and the microcode ROM of the sequencer.
// ----------------------------------------------------------------------------
package srq_pkg;

    localparam int SRQ_WINDOW      = 8;
    localparam int SRQ_MAX_RESULTS = 8;
    localparam int SRQ_N_W         = $clog2(SRQ_MAX_RESULTS + 1);

    // event kinds
    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_ACK     = 2'd1;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd2;
    localparam logic [1:0] FUNC_IDLE    = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_NEW  = 2'd0;
    localparam logic [1:0] KIND_RETX = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // ack status
    localparam logic [1:0] ST_ACCEPT  = 2'd0;
    localparam logic [1:0] ST_DISCARD = 2'd1;
    localparam logic [1:0] ST_NOT_ACK = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] ack_seq;
    } srq_in_t;

    typedef struct packed {
        logic [15:0] tx_seq;
        logic [1:0]  tx_kind;
        logic [1:0]  ack_status;
        logic        last;
    } srq_out_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_START,
        OP_ACK,
        OP_SLIDE,
        OP_REFILL,
        OP_END,
        OP_FINISH,
        OP_TO_INIT,
        OP_RETX
    } uop_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_SKIP,
        C_IS_START,
        C_IS_TIMEOUT,
        C_NO_SLIDE,
        C_CAN_SLIDE,
        C_NOT_STARTED,
        C_CAN_REFILL,
        C_TO_MORE
    } ucond_t;

    typedef logic [3:0] upc_t;

    localparam upc_t UA_WAIT       = 4'd0;
    localparam upc_t UA_DISPATCH   = 4'd1;
    localparam upc_t UA_START      = 4'd2;
    localparam upc_t UA_SELECT     = 4'd3;
    localparam upc_t UA_ACK        = 4'd4;
    localparam upc_t UA_SLIDE      = 4'd5;
    localparam upc_t UA_REFILL_CHK = 4'd6;
    localparam upc_t UA_REFILL     = 4'd7;
    localparam upc_t UA_END        = 4'd8;
    localparam upc_t UA_FIN        = 4'd9;
    localparam upc_t UA_TO_INIT    = 4'd10;
    localparam upc_t UA_RETX       = 4'd11;
    localparam upc_t UA_TO_DONE    = 4'd12;

    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        upc_t   target;
    } ucode_t;

    // One control word per step; a taken condition jumps to target,
    // otherwise the step counter advances by one.
    function automatic ucode_t ucode_rom(upc_t addr);
        ucode_t w;
        case (addr)
            UA_WAIT:       w = '{op: OP_LATCH,   cond: C_NO_ACCEPT,   target: UA_WAIT};
            UA_DISPATCH:   w = '{op: OP_NOP,     cond: C_SKIP,        target: UA_FIN};
            UA_START:      w = '{op: OP_START,   cond: C_IS_START,    target: UA_REFILL_CHK};
            UA_SELECT:     w = '{op: OP_NOP,     cond: C_IS_TIMEOUT,  target: UA_TO_INIT};
            UA_ACK:        w = '{op: OP_ACK,     cond: C_NO_SLIDE,    target: UA_REFILL_CHK};
            UA_SLIDE:      w = '{op: OP_SLIDE,   cond: C_CAN_SLIDE,   target: UA_SLIDE};
            UA_REFILL_CHK: w = '{op: OP_NOP,     cond: C_NOT_STARTED, target: UA_FIN};
            UA_REFILL:     w = '{op: OP_REFILL,  cond: C_CAN_REFILL,  target: UA_REFILL};
            UA_END:        w = '{op: OP_END,     cond: C_NEVER,       target: UA_WAIT};
            UA_FIN:        w = '{op: OP_FINISH,  cond: C_ALWAYS,      target: UA_WAIT};
            UA_TO_INIT:    w = '{op: OP_TO_INIT, cond: C_NEVER,       target: UA_WAIT};
            UA_RETX:       w = '{op: OP_RETX,    cond: C_TO_MORE,     target: UA_RETX};
            UA_TO_DONE:    w = '{op: OP_NOP,     cond: C_ALWAYS,      target: UA_REFILL_CHK};
            default:       w = '{op: OP_NOP,     cond: C_ALWAYS,      target: UA_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/selective_repeat_arq_sender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_arq_sender: selective-repeat ARQ sender window
// Microcoded sequencer over a small window datapath (base, next, ack bits).
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel (valid/ready): one event per item, func = start, ack or
//   timeout, ack_seq used for acks. s_ready is high only while the sequencer
//   sits in its wait step; one event is worked on at a time.
//   m_* channel (valid/ready): one item per transmission (new frame,
//   retransmission, end marker) or a single nothing-sent item; last marks the
//   final item of an event. At most SRQ_MAX_RESULTS items per event.
//   cfg_wr_en/cfg_wr_data write frame_total; write it only while idle.
// Sequencing: one control word per cycle while no result stalls. A skipped
//   event (after done, or the unused code) goes straight to the closing
//   step; before start, an ack or timeout skips the refill. The slide,
//   window-scan and refill steps repeat while their condition holds.
//   A result waits in the pending stage until the next result or the
//   closing step moves it out; the final item appears together with
//   s_ready.
// Reset (aresetn low, synchronous): window empty, transfer not started,
//   frame_total zero, output empty, s_ready low.
// Stall: results pass through a one-deep pending stage and an output
//   register; a result due to move into it while m_ready is low stalls the sequencer.
// ----------------------------------------------------------------------------
module selective_repeat_arq_sender #(
    parameter int WINDOW = srq_pkg::SRQ_WINDOW
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  srq_pkg::srq_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output srq_pkg::srq_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data
);
    import srq_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int IDX_W  = $clog2(WINDOW + 1);
    localparam logic [SLOT_W:0]  WIN_WIDE = (SLOT_W + 1)'(WINDOW);
    localparam logic [IDX_W-1:0] WIN_IDX  = IDX_W'(WINDOW);

    typedef logic [SLOT_W-1:0] slot_t;

    // step a slot pointer with wrap at the window size
    function automatic slot_t slot_inc(slot_t s);
        return (s == slot_t'(WINDOW - 1)) ? '0 : s + slot_t'(1);
    endfunction

    // sequencer
    upc_t     upc_reg, upc_next;
    ucode_t   uw;
    logic     take;
    logic     stall;
    logic     s_accept;

    // window state
    logic [15:0]       frame_total_reg, frame_total_next;
    logic [15:0]       base_reg, base_next;
    logic [15:0]       next_reg, next_next;
    slot_t             base_slot_reg, base_slot_next;
    slot_t             next_slot_reg, next_slot_next;
    logic [WINDOW-1:0] acked_reg, acked_next;
    logic              started_reg, started_next;
    logic              done_reg, done_next;

    // per-event working registers
    logic [1:0]        func_reg, func_next;
    logic [15:0]       ack_reg, ack_next;
    logic [1:0]        status_reg, status_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    slot_t             scan_slot_reg, scan_slot_next;
    logic [SRQ_N_W-1:0] n_reg, n_next;

    // result path: pending stage, then output register
    logic     pend_valid_reg, pend_valid_next;
    srq_out_t pend_reg, pend_next;
    logic     out_valid_reg, out_valid_next;
    srq_out_t out_reg, out_next;
    logic     out_busy;

    // datapath predicates
    logic [15:0]     ack_off;
    logic [SLOT_W:0] ack_sum;
    slot_t           ack_slot;
    logic            ack_in_win;
    logic            can_slide;
    logic [16:0]     base_lim;
    logic            n_full;
    logic            can_refill;
    logic [15:0]     span;
    logic            to_more;
    logic            end_ok;

    // emit request decoded from the current control word
    logic        emit_req;
    logic [15:0] emit_seq;
    logic [1:0]  emit_kind;
    logic        fin_req;

    // hold the input off while reset is applied
    assign s_ready  = aresetn && (upc_reg == UA_WAIT);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign out_busy = out_valid_reg && !m_ready;

    assign uw = ucode_rom(upc_reg);

    // ack lands in slot (base_slot + ack - base) mod WINDOW
    assign ack_off    = ack_reg - base_reg;
    assign ack_sum    = {1'b0, base_slot_reg} + {1'b0, ack_off[SLOT_W-1:0]};
    assign ack_slot   = (ack_sum >= WIN_WIDE) ? slot_t'(ack_sum - WIN_WIDE)
                                               : ack_sum[SLOT_W-1:0];
    assign ack_in_win = (ack_reg >= base_reg) && (ack_reg < next_reg);
    assign can_slide  = (base_reg < next_reg) && acked_reg[base_slot_reg];
    assign base_lim   = {1'b0, base_reg} + 17'(WINDOW);
    assign n_full     = (n_reg >= SRQ_N_W'(SRQ_MAX_RESULTS));
    assign can_refill = ({1'b0, next_reg} < base_lim) && (next_reg < frame_total_reg)
                        && !n_full;
    assign span       = next_reg - base_reg;
    assign to_more    = (idx_reg < WIN_IDX) && (span > 16'(idx_reg));
    assign end_ok     = (base_reg >= frame_total_reg) && !n_full;

    // jump condition
    always_comb begin
        case (uw.cond)
            C_NEVER:       take = 1'b0;
            C_ALWAYS:      take = 1'b1;
            C_NO_ACCEPT:   take = !s_accept;
            C_SKIP:        take = done_reg || (func_reg == FUNC_IDLE);
            C_IS_START:    take = (func_reg == FUNC_START);
            C_IS_TIMEOUT:  take = (func_reg == FUNC_TIMEOUT);
            C_NO_SLIDE:    take = !(ack_in_win && (ack_reg == base_reg));
            C_CAN_SLIDE:   take = can_slide;
            C_NOT_STARTED: take = !started_reg;
            C_CAN_REFILL:  take = can_refill;
            C_TO_MORE:     take = to_more;
            default:       take = 1'b0;
        endcase
    end

    // decode result requests of this step
    always_comb begin
        emit_req  = 1'b0;
        emit_seq  = '0;
        emit_kind = KIND_NONE;
        fin_req   = 1'b0;
        case (uw.op)
            OP_REFILL: begin
                if (can_refill) begin
                    emit_req  = 1'b1;
                    emit_seq  = next_reg;
                    emit_kind = KIND_NEW;
                end
            end
            OP_END: begin
                if (end_ok) begin
                    emit_req  = 1'b1;
                    emit_kind = KIND_END;
                end
            end
            OP_RETX: begin
                if (to_more && !acked_reg[scan_slot_reg]) begin
                    emit_req  = 1'b1;
                    emit_seq  = base_reg + 16'(idx_reg);
                    emit_kind = KIND_RETX;
                end
            end
            OP_FINISH: fin_req = 1'b1;
            default: ;
        endcase
    end

    // hold the step when a result must move into a full output register
    assign stall = out_busy && ((emit_req && !n_full && pend_valid_reg) || fin_req);

    // next state
    always_comb begin
        upc_next         = upc_reg;
        frame_total_next = cfg_wr_en ? cfg_wr_data : frame_total_reg;
        base_next        = base_reg;
        next_next        = next_reg;
        base_slot_next   = base_slot_reg;
        next_slot_next   = next_slot_reg;
        acked_next       = acked_reg;
        started_next     = started_reg;
        done_next        = done_reg;
        func_next        = func_reg;
        ack_next         = ack_reg;
        status_next      = status_reg;
        idx_next         = idx_reg;
        scan_slot_next   = scan_slot_reg;
        n_next           = n_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_next         = out_reg;

        if (!stall) begin
            upc_next = take ? uw.target : upc_reg + upc_t'(1);

            case (uw.op)
                OP_LATCH: begin
                    if (s_accept) begin
                        func_next   = s_data.func;
                        ack_next    = s_data.ack_seq;
                        status_next = (s_data.func == FUNC_ACK) ? ST_DISCARD : ST_NOT_ACK;
                    end
                end
                OP_START: begin
                    if (func_reg == FUNC_START) begin
                        started_next = 1'b1;
                    end
                end
                OP_ACK: begin
                    if (ack_in_win) begin
                        status_next          = ST_ACCEPT;
                        acked_next[ack_slot] = 1'b1;
                    end
                end
                OP_SLIDE: begin
                    if (can_slide) begin
                        base_next      = base_reg + 16'd1;
                        base_slot_next = slot_inc(base_slot_reg);
                    end
                end
                OP_REFILL: begin
                    if (can_refill) begin
                        acked_next[next_slot_reg] = 1'b0;
                        next_next                 = next_reg + 16'd1;
                        next_slot_next            = slot_inc(next_slot_reg);
                    end
                end
                OP_END: begin
                    if (end_ok) begin
                        done_next = 1'b1;
                    end
                end
                OP_TO_INIT: begin
                    idx_next       = '0;
                    scan_slot_next = base_slot_reg;
                end
                OP_RETX: begin
                    if (to_more) begin
                        idx_next       = idx_reg + IDX_W'(1);
                        scan_slot_next = slot_inc(scan_slot_reg);
                    end
                end
                default: ;
            endcase

            // push the older pending result out, park the new one
            if (emit_req && !n_full) begin
                if (pend_valid_reg) begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                end
                pend_valid_next = 1'b1;
                pend_next       = '{tx_seq: emit_seq, tx_kind: emit_kind,
                                    ack_status: status_reg, last: 1'b0};
                n_next          = n_reg + SRQ_N_W'(1);
            end

            // close the event: last on the pending result, or a nothing-sent item
            if (fin_req) begin
                out_valid_next = 1'b1;
                if (pend_valid_reg) begin
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                end else begin
                    out_next = '{tx_seq: 16'd0, tx_kind: KIND_NONE,
                                 ack_status: status_reg, last: 1'b1};
                end
                pend_valid_next = 1'b0;
                n_next          = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg         <= UA_WAIT;
            frame_total_reg <= '0;
            base_reg        <= '0;
            next_reg        <= '0;
            base_slot_reg   <= '0;
            next_slot_reg   <= '0;
            acked_reg       <= '0;
            started_reg     <= 1'b0;
            done_reg        <= 1'b0;
            n_reg           <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            upc_reg         <= upc_next;
            frame_total_reg <= frame_total_next;
            base_reg        <= base_next;
            next_reg        <= next_next;
            base_slot_reg   <= base_slot_next;
            next_slot_reg   <= next_slot_next;
            acked_reg       <= acked_next;
            started_reg     <= started_next;
            done_reg        <= done_next;
            n_reg           <= n_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
        func_reg      <= func_next;
        ack_reg       <= ack_next;
        status_reg    <= status_next;
        idx_reg       <= idx_next;
        scan_slot_reg <= scan_slot_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
    end

endmodule

>>> rtl/core/srq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srq_checker: port-level checks for the selective-repeat sender
// Watches the result channel over time; bound to the top level below.
// ----------------------------------------------------------------------------
module srq_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input srq_pkg::srq_out_t m_data
);
    import srq_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // end marker and nothing-sent items always close their event
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.tx_kind == KIND_END || m_data.tx_kind == KIND_NONE)
        |-> m_data.last)
        else $error("end or nothing-sent item not marked last");

    // end marker and nothing-sent items carry sequence zero
    a_marker_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.tx_kind == KIND_END || m_data.tx_kind == KIND_NONE)
        |-> m_data.tx_seq == 16'd0)
        else $error("marker item with nonzero sequence");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind selective_repeat_arq_sender srq_checker u_srq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
